FILE: design/pot_pkg.sv
package pot_pkg;

  localparam int MAX_VALUES  = 16;
  localparam int IDX_W       = $clog2(MAX_VALUES);
  localparam int TABLE_DEPTH = MAX_VALUES * MAX_VALUES;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int DOM_W       = 5;
  localparam int CNT_W       = 9;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_LEARN  = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_COMM   = 3'd3;
  localparam logic [2:0] OP_IDENT  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_DOMAIN   = 2'd2;
  localparam logic [1:0] ST_UNARY    = 2'd3;

  localparam logic [1:0] CFG_ARITY    = 2'd0;
  localparam logic [1:0] CFG_DOMAIN_A = 2'd1;
  localparam logic [1:0] CFG_DOMAIN_B = 2'd2;

  localparam logic [1:0] ARITY_BINARY = 2'd2;

  typedef struct packed {
    logic accept;
    logic scan_issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_req;
    logic scan_last;
  } dp_stat_t;

endpackage

FILE: design/pot_ctrl.sv
module pot_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pot_pkg::dp_stat_t  stat,
  output pot_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import pot_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd.accept     = 1'b0;
    cmd.scan_issue = 1'b0;
    cmd.finish     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.scan_req ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: design/pot_dp.sv
module pot_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pot_pkg::ctrl_cmd_t cmd,
  output pot_pkg::dp_stat_t  stat,
  input  logic [2:0]         in_operation,
  input  logic [3:0]         in_arg_a,
  input  logic [3:0]         in_arg_b,
  input  logic [3:0]         in_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_grounded,
  output logic [3:0]         out_stored_value,
  output logic               out_matches_res,
  output logic               out_verdict,
  output logic [3:0]         out_found_a,
  output logic [3:0]         out_found_b,
  output logic [8:0]         out_grounded_count
);
  import pot_pkg::*;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b,
                                                input logic [DOM_W-1:0] db);
    logic [IDX_W+DOM_W-1:0] full;
    full = ({{DOM_W{1'b0}}, a} * {{IDX_W{1'b0}}, db}) + {{DOM_W{1'b0}}, b};
    return full[ADDR_W-1:0];
  endfunction

  localparam logic [DOM_W-1:0] MAX_DOM  = DOM_W'(MAX_VALUES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VALUES - 1);

  logic [1:0]       arity_r;
  logic [DOM_W-1:0] domain_a_r;
  logic [DOM_W-1:0] domain_b_r;

  logic             binary;
  logic [DOM_W-1:0] eff_da;
  logic [DOM_W-1:0] eff_db;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [3:0]             mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]      rd_addr_a;
  logic [ADDR_W-1:0]      rd_addr_b;
  logic [3:0]             rd_a_r;
  logic [3:0]             rd_b_r;

  logic [IDX_W-1:0]  in_b_eff;
  logic              in_dom;
  logic [ADDR_W-1:0] in_addr;

  logic [2:0]        op_r;
  logic [3:0]        v_r;
  logic [ADDR_W-1:0] addr_r;
  logic              indom_r;
  logic              grd_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              do_write;

  logic [ADDR_W-1:0] scan_cnt_r;
  logic [IDX_W-1:0]  sc_i;
  logic [IDX_W-1:0]  sc_j;
  logic [ADDR_W-1:0] sc_addr_a;
  logic [ADDR_W-1:0] sc_addr_b;
  logic              sc_dom_a;
  logic              sc_dom_b;

  logic              s_vld_r;
  logic [IDX_W-1:0]  s_i_r;
  logic [IDX_W-1:0]  s_j_r;
  logic              s_ga_r;
  logic              s_gb_r;

  logic              shared_r;
  logic              diff_r;
  logic [IDX_W-1:0]  comm_a_r;
  logic [IDX_W-1:0]  comm_b_r;
  logic              row_ok_r;
  logic              row_chk_r;
  logic              id_found_r;
  logic [IDX_W-1:0]  id_c_r;

  logic              both;
  logic              id_fail;
  logic              ok_now;
  logic              chk_now;

  logic              out_valid_r;
  logic [1:0]        status_r;
  logic              grounded_r;
  logic [3:0]        stored_r;
  logic              match_r;
  logic              verdict_r;
  logic [3:0]        found_a_r;
  logic [3:0]        found_b_r;
  logic [CNT_W-1:0]  gcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arity_r    <= ARITY_BINARY;
      domain_a_r <= MAX_DOM;
      domain_b_r <= MAX_DOM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARITY:    arity_r    <= cfg_data[1:0];
        CFG_DOMAIN_A: domain_a_r <= cfg_data;
        CFG_DOMAIN_B: domain_b_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign binary = (arity_r == ARITY_BINARY);
  assign eff_da = (domain_a_r > MAX_DOM) ? MAX_DOM : domain_a_r;
  assign eff_db = !binary ? DOM_W'(1) : ((domain_b_r > MAX_DOM) ? MAX_DOM : domain_b_r);

  assign in_b_eff = binary ? in_arg_b : '0;
  assign in_dom   = ({{(DOM_W-IDX_W){1'b0}}, in_arg_a} < eff_da) &&
                    ({{(DOM_W-IDX_W){1'b0}}, in_b_eff} < eff_db);
  assign in_addr  = slot_of(in_arg_a, in_b_eff, eff_db);

  assign sc_i      = scan_cnt_r[ADDR_W-1:IDX_W];
  assign sc_j      = scan_cnt_r[IDX_W-1:0];
  assign sc_addr_a = slot_of(sc_i, sc_j, eff_db);
  assign sc_addr_b = slot_of(sc_j, sc_i, eff_db);
  assign sc_dom_a  = ({{(DOM_W-IDX_W){1'b0}}, sc_i} < eff_da) &&
                     ({{(DOM_W-IDX_W){1'b0}}, sc_j} < eff_db);
  assign sc_dom_b  = ({{(DOM_W-IDX_W){1'b0}}, sc_j} < eff_da) &&
                     ({{(DOM_W-IDX_W){1'b0}}, sc_i} < eff_db);

  assign rd_addr_a = cmd.scan_issue ? sc_addr_a : in_addr;
  assign rd_addr_b = sc_addr_b;

  assign stat.scan_req  = binary && ((in_operation == OP_COMM) || (in_operation == OP_IDENT));
  assign stat.scan_last = (scan_cnt_r == {ADDR_W{1'b1}});

  assign do_write = cmd.finish && (op_r == OP_LEARN) && indom_r && !grd_r;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[addr_r] <= v_r;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.finish && (op_r == OP_CLEAR)) begin
      valid_r <= '0;
    end else if (do_write) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish && (op_r == OP_CLEAR)) begin
      count_nxt = '0;
    end else if (do_write) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_operation;
      v_r     <= in_value;
      addr_r  <= in_addr;
      indom_r <= in_dom;
      grd_r   <= in_dom && valid_r[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      s_vld_r    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_cnt_r <= scan_cnt_r + ADDR_W'(1);
      end
      s_vld_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    s_i_r  <= sc_i;
    s_j_r  <= sc_j;
    s_ga_r <= sc_dom_a && valid_r[sc_addr_a];
    s_gb_r <= sc_dom_b && valid_r[sc_addr_b];
  end

  assign both    = s_ga_r && s_gb_r;
  assign id_fail = (s_ga_r && (rd_a_r != s_j_r)) || (s_gb_r && (rd_b_r != s_j_r));
  assign ok_now  = row_ok_r && !id_fail;
  assign chk_now = row_chk_r || s_ga_r || s_gb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_r   <= 1'b0;
      diff_r     <= 1'b0;
      row_ok_r   <= 1'b1;
      row_chk_r  <= 1'b0;
      id_found_r <= 1'b0;
    end else if (cmd.accept) begin
      shared_r   <= 1'b0;
      diff_r     <= 1'b0;
      row_ok_r   <= 1'b1;
      row_chk_r  <= 1'b0;
      id_found_r <= 1'b0;
    end else if (s_vld_r) begin
      if (both) begin
        shared_r <= 1'b1;
      end
      if (both && (rd_a_r != rd_b_r) && !diff_r) begin
        diff_r <= 1'b1;
      end
      if (s_j_r == LAST_IDX) begin
        row_ok_r  <= 1'b1;
        row_chk_r <= 1'b0;
        if (ok_now && chk_now && !id_found_r) begin
          id_found_r <= 1'b1;
        end
      end else begin
        row_ok_r  <= ok_now;
        row_chk_r <= chk_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      comm_a_r <= '0;
      comm_b_r <= '0;
      id_c_r   <= '0;
    end else if (s_vld_r) begin
      if (both && (rd_a_r != rd_b_r) && !diff_r) begin
        comm_a_r <= s_i_r;
        comm_b_r <= s_j_r;
      end
      if ((s_j_r == LAST_IDX) && ok_now && chk_now && !id_found_r) begin
        id_c_r <= s_i_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r   <= ST_OK;
      grounded_r <= 1'b0;
      stored_r   <= '0;
      match_r    <= 1'b0;
      verdict_r  <= 1'b0;
      found_a_r  <= '0;
      found_b_r  <= '0;
      gcount_r   <= count_nxt;
      case (op_r)
        OP_LEARN: begin
          if (!indom_r) begin
            status_r <= ST_DOMAIN;
          end else if (grd_r && (rd_a_r != v_r)) begin
            status_r <= ST_CONFLICT;
          end
        end
        OP_LOOKUP: begin
          if (!indom_r) begin
            status_r <= ST_DOMAIN;
          end else begin
            grounded_r <= grd_r;
            stored_r   <= grd_r ? rd_a_r : 4'd0;
            match_r    <= grd_r && (rd_a_r == v_r);
          end
        end
        OP_COMM: begin
          if (!binary) begin
            status_r <= ST_UNARY;
          end else begin
            verdict_r <= !diff_r && shared_r;
            found_a_r <= 4'(comm_a_r);
            found_b_r <= 4'(comm_b_r);
          end
        end
        OP_IDENT: begin
          if (!binary) begin
            status_r <= ST_UNARY;
          end else begin
            verdict_r <= id_found_r;
            found_a_r <= 4'(id_c_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_grounded       = grounded_r;
  assign out_stored_value   = stored_r;
  assign out_matches_res    = match_r;
  assign out_verdict        = verdict_r;
  assign out_found_a        = found_a_r;
  assign out_found_b        = found_b_r;
  assign out_grounded_count = gcount_r;

endmodule

FILE: design/partial_operation_table_top.sv
// Partial operation table: learns a one or two argument operation from examples.
// An item is taken at a rising edge where start is high and busy is low; its
// fields are operation, arg_a, arg_b and value. Every item gives exactly one
// result beat, shown on the out_ ports for a single cycle while out_valid is high.
// Clear, learn, lookup, unknown operations and queries on a unary table read the
// table memory at the accepting edge; the item completes in the next cycle and its
// result beat appears in the cycle after that, during which a new item may already
// be accepted. The commutativity and identity queries walk all 256 argument pairs
// through the two read ports of the answer memory, one pair per cycle; busy stays
// high through the scan, drain and finish states, and the result beat follows in
// the next cycle. Configuration (arity, domain_a, domain_b) is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while the block is
// idle, which the block does not enforce; domain changes do not clear the table.
// Synchronous reset sets binary arity with both domains at 16, clears every valid
// bit and the entry count, and leaves the answer memory as it was.
// The receiver cannot hold a result back, so no result is ever stalled.
module partial_operation_table_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [3:0] in_arg_a,
  input  logic [3:0] in_arg_b,
  input  logic [3:0] in_value,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic       out_grounded,
  output logic [3:0] out_stored_value,
  output logic       out_matches_res,
  output logic       out_verdict,
  output logic [3:0] out_found_a,
  output logic [3:0] out_found_b,
  output logic [8:0] out_grounded_count
);
  import pot_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pot_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pot_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_arg_a           (in_arg_a),
    .in_arg_b           (in_arg_b),
    .in_value           (in_value),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_grounded       (out_grounded),
    .out_stored_value   (out_stored_value),
    .out_matches_res    (out_matches_res),
    .out_verdict        (out_verdict),
    .out_found_a        (out_found_a),
    .out_found_b        (out_found_b),
    .out_grounded_count (out_grounded_count)
  );

endmodule

FILE: bench/partial_operation_table_top_tb.sv
module partial_operation_table_top_tb;
  import pot_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 270;
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEM_TARGET  = 600;
  localparam int CALM_TAIL    = 80;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_CODE    = 3'd7;
  localparam logic [1:0] CFG_SPARE       = 2'd3;
  localparam logic [1:0] ARITY_UNARY     = 2'd1;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} plan_kind_e;

  typedef struct {
    plan_kind_e kind;
    logic       quiet;
    logic [2:0] op;
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] v;
    logic [1:0] idx;
    logic [4:0] data;
  } plan_t;

  typedef struct packed {
    logic [1:0] status;
    logic       grounded;
    logic [3:0] stored_value;
    logic       matches_res;
    logic       verdict;
    logic [3:0] found_a;
    logic [3:0] found_b;
    logic [8:0] grounded_count;
  } table_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_operation = '0;
  logic [3:0] in_arg_a = '0;
  logic [3:0] in_arg_b = '0;
  logic [3:0] in_value = '0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  logic       out_valid;
  logic [1:0] out_status;
  logic       out_grounded;
  logic [3:0] out_stored_value;
  logic       out_matches_res;
  logic       out_verdict;
  logic [3:0] out_found_a;
  logic [3:0] out_found_b;
  logic [8:0] out_grounded_count;

  partial_operation_table_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_arg_a(in_arg_a), .in_arg_b(in_arg_b),
    .in_value(in_value), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_status(out_status), .out_grounded(out_grounded),
    .out_stored_value(out_stored_value), .out_matches_res(out_matches_res),
    .out_verdict(out_verdict), .out_found_a(out_found_a), .out_found_b(out_found_b),
    .out_grounded_count(out_grounded_count)
  );

  always #4 clk = ~clk;

  // Shadow copy of the table and its registers.
  logic       tbl_valid [TABLE_DEPTH];
  logic [3:0] tbl_ans [TABLE_DEPTH];
  int         tbl_count = 0;
  logic [1:0] sh_arity = ARITY_BINARY;
  logic [4:0] sh_dom_a = 5'd16;
  logic [4:0] sh_dom_b = 5'd16;

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
  end

  plan_t       pending_q [$];
  table_beat_t table_beats_due [$];
  int          sent_cnt = 0;
  int          acc_cnt = 0;
  int          gap_left = 0;
  int          drain_wait = 0;
  int          cycle_no = 0;
  int          fail_count = 0;
  int          item_total = 0;
  int          op_seen [8];
  int          cfg_writes = 0;
  int          n_conflict = 0;
  int          n_domain = 0;
  int          n_unary = 0;
  int          n_verdict = 0;

  // Plan-time state, used only to shape the stimulus.
  logic       plan_quiet = 1'b0;
  logic [3:0] goal_op [16][16];

  function automatic bit is_binary();
    return sh_arity == ARITY_BINARY;
  endfunction

  function automatic int span_a();
    return (sh_dom_a > MAX_VALUES) ? MAX_VALUES : int'(sh_dom_a);
  endfunction

  function automatic int span_b();
    if (!is_binary()) return 1;
    return (sh_dom_b > MAX_VALUES) ? MAX_VALUES : int'(sh_dom_b);
  endfunction

  function automatic bit in_dom(int a, int b);
    return a < span_a() && b < span_b();
  endfunction

  function automatic int slot_of(int a, int b);
    return (a * span_b() + b) % TABLE_DEPTH;
  endfunction

  function automatic bit grounded_at(int a, int b);
    return in_dom(a, b) && tbl_valid[slot_of(a, b)];
  endfunction

  function automatic table_beat_t table_apply(logic [2:0] op, logic [3:0] a_in,
                                              logic [3:0] b_in, logic [3:0] v);
    table_beat_t r;
    int a, b, x, y, c, checked;
    bit diff, ok;
    r = '0;
    a = a_in;
    b = is_binary() ? int'(b_in) : 0;
    case (op)
      OP_CLEAR: begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        tbl_count = 0;
      end
      OP_LEARN: begin
        if (!in_dom(a, b)) begin
          r.status = ST_DOMAIN;
        end else if (grounded_at(a, b)) begin
          if (tbl_ans[slot_of(a, b)] != v) r.status = ST_CONFLICT;
        end else begin
          tbl_valid[slot_of(a, b)] = 1'b1;
          tbl_ans[slot_of(a, b)] = v;
          tbl_count++;
        end
      end
      OP_LOOKUP: begin
        if (!in_dom(a, b)) begin
          r.status = ST_DOMAIN;
        end else if (grounded_at(a, b)) begin
          r.grounded = 1'b1;
          r.stored_value = tbl_ans[slot_of(a, b)];
          r.matches_res = (r.stored_value == v);
        end
      end
      OP_COMM: begin
        if (!is_binary()) begin
          r.status = ST_UNARY;
        end else begin
          diff = 1'b0;
          checked = 0;
          for (x = 0; x < MAX_VALUES && !diff; x++) begin
            for (y = 0; y < MAX_VALUES && !diff; y++) begin
              if (grounded_at(x, y) && grounded_at(y, x)) begin
                checked++;
                if (tbl_ans[slot_of(x, y)] != tbl_ans[slot_of(y, x)]) begin
                  diff = 1'b1;
                  r.found_a = x[3:0];
                  r.found_b = y[3:0];
                end
              end
            end
          end
          r.verdict = !diff && checked > 0;
        end
      end
      OP_IDENT: begin
        if (!is_binary()) begin
          r.status = ST_UNARY;
        end else begin
          for (c = 0; c < MAX_VALUES && !r.verdict; c++) begin
            checked = 0;
            ok = 1'b1;
            for (x = 0; x < MAX_VALUES && ok; x++) begin
              if (grounded_at(x, c)) begin
                checked++;
                ok = (tbl_ans[slot_of(x, c)] == x[3:0]);
              end
              if (ok && grounded_at(c, x)) begin
                checked++;
                ok = (tbl_ans[slot_of(c, x)] == x[3:0]);
              end
            end
            if (ok && checked > 0) begin
              r.verdict = 1'b1;
              r.found_a = c[3:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.grounded_count = (tbl_count > 511) ? 9'd511 : tbl_count[8:0];
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic add_item(logic [2:0] op, logic [3:0] a, logic [3:0] b, logic [3:0] v);
    plan_t p;
    p = '{kind: K_ITEM, quiet: plan_quiet, op: op, a: a, b: b, v: v, idx: '0, data: '0};
    pending_q.push_back(p);
    item_total++;
  endtask

  task automatic add_drain();
    plan_t p;
    p = '{kind: K_DRAIN, quiet: plan_quiet, op: '0, a: '0, b: '0, v: '0, idx: '0, data: '0};
    pending_q.push_back(p);
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [4:0] data);
    plan_t p;
    p = '{kind: K_CFG, quiet: plan_quiet, op: '0, a: '0, b: '0, v: '0, idx: idx, data: data};
    pending_q.push_back(p);
  endtask

  task automatic add_phase(logic [1:0] ar, logic [4:0] da, logic [4:0] db, int n);
    int ea, eb, kind, e, r, k;
    logic [3:0] a, b, v;
    add_drain();
    add_cfg(CFG_ARITY, {3'b000, ar});
    add_cfg(CFG_DOMAIN_A, da);
    add_cfg(CFG_DOMAIN_B, db);
    if ($urandom_range(0, 5) == 0) add_cfg(CFG_SPARE, 5'($urandom_range(0, 31)));
    ea = (da > MAX_VALUES) ? MAX_VALUES : int'(da);
    eb = (ar != ARITY_BINARY) ? 1 : ((db > MAX_VALUES) ? MAX_VALUES : int'(db));
    kind = $urandom_range(0, 2);
    e = (ea > 0) ? $urandom_range(0, ea - 1) : 0;
    for (int x = 0; x < 16; x++) begin
      for (int y = 0; y < 16; y++) begin
        if (kind == 1 && y < x) goal_op[x][y] = goal_op[y][x];
        else goal_op[x][y] = 4'($urandom_range(0, 15));
      end
    end
    if (kind == 2) begin
      for (int x = 0; x < 16; x++) begin
        goal_op[x][e] = x[3:0];
        goal_op[e][x] = x[3:0];
      end
    end
    if ($urandom_range(0, 1) == 0) add_item(OP_CLEAR, 4'($urandom), 4'($urandom), 4'($urandom));
    for (k = 0; k < n; k++) begin
      a = (ea > 0 && $urandom_range(0, 9) != 0) ? 4'($urandom_range(0, ea - 1))
                                                : 4'($urandom_range(0, 15));
      b = (ar == ARITY_BINARY && eb > 0 && $urandom_range(0, 9) != 0)
          ? 4'($urandom_range(0, eb - 1)) : 4'($urandom_range(0, 15));
      v = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : goal_op[a][b];
      r = $urandom_range(0, 99);
      if (r < 40) add_item(OP_LEARN, a, b, v);
      else if (r < 72) add_item(OP_LOOKUP, a, b, v);
      else if (r < 80) add_item(OP_COMM, a, b, v);
      else if (r < 88) add_item(OP_IDENT, a, b, v);
      else if (r < 91) add_item(OP_CLEAR, a, b, v);
      else if (r < 95) add_item(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE)), a, b, v);
      else add_item(3'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
    end
  endtask

  // Driver: presents one beat at a time and holds it until it is taken.
  always @(negedge clk) begin
    logic nx_start, nx_we;
    nx_start = 1'b0;
    nx_we = 1'b0;
    if (rst_n) begin
      if (sent_cnt != acc_cnt) begin
        nx_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_operation <= 3'($urandom);
        in_arg_a <= 4'($urandom);
        in_arg_b <= 4'($urandom);
        in_value <= 4'($urandom);
      end else if (pending_q.size() > 0) begin
        case (pending_q[0].kind)
          K_ITEM: begin
            nx_start = 1'b1;
            in_operation <= pending_q[0].op;
            in_arg_a <= pending_q[0].a;
            in_arg_b <= pending_q[0].b;
            in_value <= pending_q[0].v;
            sent_cnt <= sent_cnt + 1;
            if (!pending_q[0].quiet && pending_q.size() > CALM_TAIL &&
                $urandom_range(0, 5) == 0)
              gap_left <= $urandom_range(1, 19);
            void'(pending_q.pop_front());
          end
          K_CFG: begin
            nx_we = 1'b1;
            cfg_index <= pending_q[0].idx;
            cfg_data <= pending_q[0].data;
            void'(pending_q.pop_front());
          end
          default: begin
            if (table_beats_due.size() == 0 && !busy) begin
              if (drain_wait == DRAIN_CYCLES) begin
                drain_wait <= 0;
                void'(pending_q.pop_front());
              end else begin
                drain_wait <= drain_wait + 1;
              end
            end else begin
              drain_wait <= 0;
            end
          end
        endcase
      end
    end
    start <= nx_start;
    cfg_we <= nx_we;
  end

  // Monitor: checks result beats, tracks register writes and predicts accepted beats.
  always @(posedge clk) begin
    table_beat_t want, got;
    cycle_no <= cycle_no + 1;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_status, out_grounded, out_stored_value, out_matches_res, out_verdict,
                out_found_a, out_found_b, out_grounded_count};
        if (table_beats_due.size() == 0) begin
          flag_mismatch("result beat with nothing pending", 1, 0);
        end else begin
          want = table_beats_due.pop_front();
          if (got.status !== want.status) flag_mismatch("status", got.status, want.status);
          if (got.grounded !== want.grounded)
            flag_mismatch("grounded", got.grounded, want.grounded);
          if (got.stored_value !== want.stored_value)
            flag_mismatch("stored_value", got.stored_value, want.stored_value);
          if (got.matches_res !== want.matches_res)
            flag_mismatch("matches_res", got.matches_res, want.matches_res);
          if (got.verdict !== want.verdict) flag_mismatch("verdict", got.verdict, want.verdict);
          if (got.found_a !== want.found_a) flag_mismatch("found_a", got.found_a, want.found_a);
          if (got.found_b !== want.found_b) flag_mismatch("found_b", got.found_b, want.found_b);
          if (got.grounded_count !== want.grounded_count)
            flag_mismatch("grounded_count", got.grounded_count, want.grounded_count);
        end
      end
      if (cfg_we) begin
        cfg_writes++;
        case (cfg_index)
          CFG_ARITY:    sh_arity = cfg_data[1:0];
          CFG_DOMAIN_A: sh_dom_a = cfg_data;
          CFG_DOMAIN_B: sh_dom_b = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = table_apply(in_operation, in_arg_a, in_arg_b, in_value);
        table_beats_due.push_back(want);
        acc_cnt <= acc_cnt + 1;
        op_seen[in_operation]++;
        if (want.status == ST_CONFLICT) n_conflict++;
        if (want.status == ST_DOMAIN) n_domain++;
        if (want.status == ST_UNARY) n_unary++;
        if (want.verdict) n_verdict++;
      end
    end
  end

  initial begin
    wait (cycle_no == CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    foreach (op_seen[i]) op_seen[i] = 0;

    add_item(OP_LOOKUP, 4'd0, 4'd0, 4'd0);
    add_item(OP_COMM, 4'd0, 4'd0, 4'd0);
    add_item(OP_IDENT, 4'd0, 4'd0, 4'd0);
    add_item(OP_LEARN, 4'd0, 4'd0, 4'd0);
    add_item(OP_LEARN, 4'd15, 4'd15, 4'd15);
    add_item(OP_LEARN, 4'd15, 4'd15, 4'd0);
    add_item(OP_LEARN, 4'd15, 4'd15, 4'd15);
    add_item(OP_LOOKUP, 4'd15, 4'd15, 4'd15);
    add_item(OP_LOOKUP, 4'd15, 4'd15, 4'd9);
    add_item(OP_COMM, 4'd0, 4'd0, 4'd0);
    add_item(OP_LEARN, 4'd3, 4'd5, 4'd7);
    add_item(OP_LEARN, 4'd5, 4'd3, 4'd8);
    add_item(OP_COMM, 4'd15, 4'd15, 4'd15);
    add_item(OP_IDENT, 4'd15, 4'd15, 4'd15);
    for (int k = OP_FIRST_UNUSED; k <= OP_LAST_CODE; k++)
      add_item(3'(k), 4'd15, 4'd15, 4'd15);
    add_item(OP_CLEAR, 4'd0, 4'd0, 4'd0);
    add_item(OP_LOOKUP, 4'd15, 4'd15, 4'd15);
    add_drain();
    add_cfg(CFG_ARITY, {3'b000, ARITY_UNARY});
    add_cfg(CFG_DOMAIN_A, 5'd4);
    add_item(OP_LEARN, 4'd3, 4'd9, 4'd6);
    add_item(OP_LOOKUP, 4'd3, 4'd2, 4'd6);
    add_item(OP_LEARN, 4'd4, 4'd0, 4'd1);
    add_item(OP_COMM, 4'd0, 4'd0, 4'd0);
    add_item(OP_IDENT, 4'd0, 4'd0, 4'd0);
    add_drain();
    add_cfg(CFG_ARITY, {3'b000, ARITY_BINARY});
    add_cfg(CFG_DOMAIN_A, 5'd16);
    add_item(OP_LOOKUP, 4'd0, 4'd3, 4'd6);

    add_phase(2'd3, 5'd31, 5'd0, 20);
    add_phase(ARITY_BINARY, 5'd0, 5'd31, 12);
    add_phase(ARITY_BINARY, 5'd31, 5'd31, 30);
    while (item_total < ITEM_TARGET) begin
      logic [1:0] ar;
      logic [4:0] da, db;
      plan_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: begin ar = ARITY_BINARY; da = 5'd16; db = 5'd16; end
        1: begin ar = ARITY_BINARY; da = 5'd1; db = 5'd1; end
        2: begin
          ar = 2'($urandom_range(0, 3));
          da = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
          db = 5'($urandom_range(0, 31));
        end
        default: begin
          ar = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : ARITY_BINARY;
          da = 5'($urandom_range(1, 6));
          db = 5'($urandom_range(1, 6));
        end
      endcase
      add_phase(ar, da, db, $urandom_range(20, 60));
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || sent_cnt != acc_cnt || table_beats_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (table_beats_due.size() != 0)
      flag_mismatch("results never delivered", 0, table_beats_due.size());

    $display("Covered %0d beats: clear %0d, learn %0d, lookup %0d, commutativity %0d, ",
             acc_cnt, op_seen[OP_CLEAR], op_seen[OP_LEARN], op_seen[OP_LOOKUP],
             op_seen[OP_COMM]);
    $display("identity %0d, unused codes %0d; %0d register writes, %0d conflicts, %0d %s",
             op_seen[OP_IDENT], op_seen[5] + op_seen[6] + op_seen[7], cfg_writes, n_conflict,
             n_domain, $sformatf("domain refusals, %0d unary refusals, %0d verdicts set",
                                 n_unary, n_verdict));
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pot_pkg.sv
design/pot_ctrl.sv
design/pot_dp.sv
design/partial_operation_table_top.sv
bench/partial_operation_table_top_tb.sv
